>>> hdl/sme_pkg.sv
// Shared widths, opcodes, status codes and controller/datapath interface types.
`timescale 1ns / 1ps
package sme_pkg;

    localparam int DATA_W  = 32;
    localparam int ACT_W   = 4;
    localparam int IP_W    = 16;
    localparam int LIMIT_W = 16;
    localparam int STEP_W  = 17;
    localparam int COUNT_W = 7;
    localparam int STS_W   = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd30;

    localparam logic [ACT_W-1:0] OP_PUSH  = 4'd0;
    localparam logic [ACT_W-1:0] OP_ADD   = 4'd1;
    localparam logic [ACT_W-1:0] OP_SUB   = 4'd2;
    localparam logic [ACT_W-1:0] OP_MUL   = 4'd3;
    localparam logic [ACT_W-1:0] OP_DIV   = 4'd4;
    localparam logic [ACT_W-1:0] OP_PRINT = 4'd5;
    localparam logic [ACT_W-1:0] OP_JMP   = 4'd6;
    localparam logic [ACT_W-1:0] OP_DUP   = 4'd7;
    localparam logic [ACT_W-1:0] OP_HALT  = 4'd8;

    localparam logic [STS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STS_W-1:0] STS_UNKNOWN   = 3'd1;
    localparam logic [STS_W-1:0] STS_OVERFLOW  = 3'd2;
    localparam logic [STS_W-1:0] STS_UNDERFLOW = 3'd3;
    localparam logic [STS_W-1:0] STS_DIVZERO   = 3'd4;
    localparam logic [STS_W-1:0] STS_STOPPED   = 3'd5;

    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_sts_t;

endpackage

>>> hdl/sme_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module sme_div
    import sme_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] num,
    input  logic [DATA_W-1:0] den,
    output logic              done,
    output logic [DATA_W-1:0] quot
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] dm_reg;
    logic [DATA_W-1:0] rem_reg;
    logic              neg_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              ge;

    assign shifted = {rem_reg, q_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dm_reg};
    assign ge      = shifted >= {1'b0, dm_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Work on magnitudes; the sign is put back at the output.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[DATA_W-1] ? (~num + 1'b1) : num;
            dm_reg  <= den[DATA_W-1] ? (~den + 1'b1) : den;
            rem_reg <= '0;
            neg_reg <= num[DATA_W-1] ^ den[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            q_reg   <= {q_reg[DATA_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

>>> hdl/sme_ctrl.sv
// Controller: sequences capture, execute, divide wait and output register hand-off.
`timescale 1ns / 1ps
module sme_ctrl
    import sme_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_sts_t    sts,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DIV  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV:
            begin
                // hold until the quotient is ready and the output slot is free
                if (sts.div_done && out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hdl/sme_dp.sv
// Datapath: machine state, opcode decode, ALU, divider and result register.
`timescale 1ns / 1ps
module sme_dp
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic [ACT_W-1:0]   in_action,
    input  logic [DATA_W-1:0]  in_operand,
    input  ctrl_cmd_t          cmd,
    output dp_sts_t            sts,
    output logic [STS_W-1:0]   status,
    output logic               print_valid,
    output logic [DATA_W-1:0]  print_value,
    output logic [IP_W-1:0]    next_ip,
    output logic               is_running,
    output logic [COUNT_W-1:0] stack_count
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    logic [ACT_W-1:0]   act_reg;
    logic [DATA_W-1:0]  opnd_reg;
    logic [SP_W-1:0]    sp_reg;
    logic [IP_W-1:0]    ip_reg;
    logic               run_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [DATA_W-1:0]  top_reg;
    logic [DATA_W-1:0]  sec_reg;

    logic [STS_W-1:0]   o_status_reg;
    logic               o_pvalid_reg;
    logic [DATA_W-1:0]  o_pvalue_reg;
    logic [IP_W-1:0]    o_ip_reg;
    logic               o_run_reg;
    logic [COUNT_W-1:0] o_count_reg;

    logic               live;
    logic               need1;
    logic               need2;
    logic               grows;
    logic               unknown;
    logic               underflow;
    logic               overflow;
    logic [STS_W-1:0]   sts_code;
    logic [DATA_W-1:0]  res;
    logic               pvalid;
    logic [DATA_W-1:0]  pvalue;
    logic [IP_W-1:0]    ip_next;
    logic               halt;
    logic               push;
    logic [DATA_W-1:0]  prod;
    logic               div_done;
    logic [DATA_W-1:0]  div_quot;
    logic [SP_W-1:0]    sp_after;
    logic [STEP_W-1:0]  step_after;
    logic               run_after;
    logic [SP_W+COUNT_W-1:0] sp_wide;

    sme_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (sec_reg),
        .den   (top_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign live = run_reg && (step_reg <= {1'b0, limit_reg});
    assign prod = sec_reg * top_reg;

    always_comb
    begin
        need1 = 1'b0;
        need2 = 1'b0;
        grows = 1'b0;
        unique case (act_reg) inside
            OP_PUSH:
            begin
                grows = 1'b1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            begin
                need1 = 1'b1;
                need2 = 1'b1;
                grows = 1'b1;
            end
            OP_PRINT:
            begin
                need1 = 1'b1;
            end
            OP_DUP:
            begin
                need1 = 1'b1;
                grows = 1'b1;
            end
            default:
            begin
                grows = 1'b0;
            end
        endcase
    end

    assign unknown   = act_reg > OP_HALT;
    assign underflow = (need2 && (sp_reg < SP_W'(2))) || (need1 && (sp_reg == '0));
    assign overflow  = grows && (sp_reg >= SP_W'(STACK_DEPTH));

    always_comb
    begin
        sts_code = STS_OK;
        res      = '0;
        pvalid   = 1'b0;
        pvalue   = '0;
        ip_next  = ip_reg + 1'b1;
        halt     = 1'b0;
        if (!live)
        begin
            sts_code = STS_STOPPED;
            ip_next  = ip_reg;
        end
        else if (unknown)
        begin
            sts_code = STS_UNKNOWN;
        end
        else if (underflow)
        begin
            sts_code = STS_UNDERFLOW;
        end
        else if (overflow)
        begin
            sts_code = STS_OVERFLOW;
        end
        else
        begin
            unique case (act_reg)
                OP_PUSH:  res = opnd_reg;
                OP_ADD:   res = sec_reg + top_reg;
                OP_SUB:   res = sec_reg - top_reg;
                OP_MUL:   res = prod;
                OP_DIV:
                begin
                    if (top_reg == '0)
                        sts_code = STS_DIVZERO;
                    else
                        res = div_quot;
                end
                OP_PRINT:
                begin
                    pvalid = 1'b1;
                    pvalue = top_reg;
                end
                OP_JMP:   ip_next = opnd_reg[IP_W-1:0];
                OP_DUP:   res = top_reg;
                OP_HALT:  halt = 1'b1;
                default:  res = '0;
            endcase
        end
    end

    assign push       = live && grows && (sts_code == STS_OK);
    assign sp_after   = push ? (sp_reg + 1'b1) : sp_reg;
    assign step_after = live ? (step_reg + 1'b1) : step_reg;
    assign run_after  = run_reg && !halt;
    assign sp_wide    = {{COUNT_W{1'b0}}, sp_after};

    assign sts.need_div = live && !unknown && !underflow && !overflow
                          && (act_reg == OP_DIV) && (top_reg != '0);
    assign sts.div_done = div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= in_action;
            opnd_reg <= in_operand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= '0;
            ip_reg    <= '0;
            run_reg   <= 1'b1;
            step_reg  <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_data;
            if (cmd.commit && live)
            begin
                sp_reg   <= sp_after;
                ip_reg   <= ip_next;
                step_reg <= step_after;
                run_reg  <= run_after;
            end
        end
    end

    // Nothing ever pops, so only the two top entries are ever read back.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && push)
        begin
            top_reg <= res;
            sec_reg <= top_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            o_status_reg <= sts_code;
            o_pvalid_reg <= pvalid;
            o_pvalue_reg <= pvalue;
            o_ip_reg     <= ip_next;
            o_run_reg    <= run_after && (step_after <= {1'b0, limit_reg});
            o_count_reg  <= sp_wide[COUNT_W-1:0];
        end
    end

    assign status      = o_status_reg;
    assign print_valid = o_pvalid_reg;
    assign print_value = o_pvalue_reg;
    assign next_ip     = o_ip_reg;
    assign is_running  = o_run_reg;
    assign stack_count = o_count_reg;

endmodule

>>> hdl/stack_machine_executor.sv
// Top level of the stack machine executor: controller, datapath and port packing.
//
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   tuser: action; tdata: operand
//  m_*       out        m_tvalid / m_tready   tuser: status, print_valid;
//                                             tdata: print_value, next_ip, is_running,
//                                             stack_count
//  cfg_*     in         cfg_valid / cfg_ready cfg_data: step_limit
//
// An instruction passes through capture and execute; div also waits for the
// bit-serial divider. One instruction is in flight at a time.
// A new instruction is taken while the previous result waits in the output register.
// The stack starts empty after reset; step_limit resets to 30. cfg_ready is always high.
`timescale 1ns / 1ps
module stack_machine_executor
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // [31:0] operand
    input  logic [3:0]         s_tuser,   // [3:0] action
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata,   // [31:0] print_value, [47:32] next_ip,
                                          // [48] is_running, [55:49] stack_count
    output logic [3:0]         m_tuser,   // [2:0] status, [3] print_valid
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    ctrl_cmd_t          cmd;
    dp_sts_t            sts;
    logic [STS_W-1:0]   status;
    logic               print_valid;
    logic [DATA_W-1:0]  print_value;
    logic [IP_W-1:0]    next_ip;
    logic               is_running;
    logic [COUNT_W-1:0] stack_count;

    assign cfg_ready = 1'b1;

    sme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sme_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .in_action   (s_tuser),
        .in_operand  (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .status      (status),
        .print_valid (print_valid),
        .print_value (print_value),
        .next_ip     (next_ip),
        .is_running  (is_running),
        .stack_count (stack_count)
    );

    assign m_tdata = {stack_count, is_running, next_ip, print_value};
    assign m_tuser = {print_valid, status};

endmodule

>>> tb/tb_stack_machine_executor.sv
// Self-checking testbench for the stack machine executor: directed, zero-limit, random and halt phases.
`timescale 1ns / 1ps
module tb_stack_machine_executor;
    import sme_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIRECTED_LEN = 24;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 120;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTED = 50;

    // opcodes the block does not know
    localparam logic [ACT_W-1:0] OP_BAD_FIRST = 4'd9;
    localparam logic [ACT_W-1:0] OP_BAD_MID = 4'd12;
    localparam logic [ACT_W-1:0] OP_BAD_LAST = 4'd15;

    localparam logic [LIMIT_W-1:0] LIMIT_MIN = 16'h0000;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [STS_W-1:0]   status;
        logic               print_valid;
        logic [DATA_W-1:0]  print_value;
        logic [IP_W-1:0]    next_ip;
        logic               is_running;
        logic [COUNT_W-1:0] stack_count;
    } vm_result_t;

    typedef struct {
        logic [ACT_W-1:0]   act;
        logic [DATA_W-1:0]  opnd;
        bit                 typed;
        logic [STS_W-1:0]   status;
        logic               pvalid;
        logic [DATA_W-1:0]  pvalue;
        logic [IP_W-1:0]    nip;
        logic               running;
        logic [COUNT_W-1:0] depth;
    } program_row_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;
    logic [3:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [55:0]        m_tdata;
    logic [3:0]         m_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;

    // machine state as the predictor sees it
    logic [DATA_W-1:0]  vm_stack [STACK_DEPTH];
    int                 vm_sp;
    logic [IP_W-1:0]    vm_ip;
    bit                 vm_run;
    int                 vm_steps;
    logic [LIMIT_W-1:0] vm_limit;

    vm_result_t awaited_results [$];
    int         mismatches = 0;
    int         results_seen = 0;
    int         cycles = 0;
    bit         idle_on = 1'b1;

    // expectations typed in only where they can be read off directly
    program_row_t directed_program [DIRECTED_LEN] = '{
        '{OP_PRINT, 32'h0000_0000, 1'b1, STS_UNDERFLOW, 1'b0, 32'h0, 16'd1, 1'b1, 7'd0},
        '{OP_DUP, 32'h5A5A_5A5A, 1'b1, STS_UNDERFLOW, 1'b0, 32'h0, 16'd2, 1'b1, 7'd0},
        '{OP_PUSH, 32'h7FFF_FFFF, 1'b1, STS_OK, 1'b0, 32'h0, 16'd3, 1'b1, 7'd1},
        '{OP_ADD, 32'h0000_0000, 1'b1, STS_UNDERFLOW, 1'b0, 32'h0, 16'd4, 1'b1, 7'd1},
        '{OP_PUSH, 32'h8000_0000, 1'b1, STS_OK, 1'b0, 32'h0, 16'd5, 1'b1, 7'd2},
        '{OP_ADD, 32'hFFFF_FFFF, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_SUB, 32'h0000_0000, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_MUL, 32'h8000_0000, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_PRINT, 32'h7FFF_FFFF, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_PUSH, 32'h0000_0000, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_DIV, 32'h0000_0000, 1'b1, STS_DIVZERO, 1'b0, 32'h0, 16'd11, 1'b1, 7'd6},
        '{OP_PUSH, 32'h8000_0000, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_PUSH, 32'hFFFF_FFFF, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_DIV, 32'h0000_0000, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_PRINT, 32'h0000_0000, 1'b1, STS_OK, 1'b1, 32'h8000_0000, 16'd15, 1'b1, 7'd9},
        '{OP_PUSH, 32'hFFFF_FFF9, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_PUSH, 32'h0000_0002, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_DIV, 32'h0000_0000, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_BAD_FIRST, 32'h0000_0000, 1'b1, STS_UNKNOWN, 1'b0, 32'h0, 16'd19, 1'b1, 7'd12},
        '{OP_BAD_LAST, 32'hFFFF_FFFF, 1'b1, STS_UNKNOWN, 1'b0, 32'h0, 16'd20, 1'b1, 7'd12},
        '{OP_JMP, 32'h1234_FFFF, 1'b1, STS_OK, 1'b0, 32'h0, 16'hFFFF, 1'b1, 7'd12},
        '{OP_DUP, 32'h0000_0000, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_JMP, 32'h8000_0005, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0},
        '{OP_BAD_MID, 32'h0000_0000, 1'b0, STS_OK, 1'b0, 32'h0, 16'd0, 1'b0, 7'd0}
    };

    stack_machine_executor #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic bit vm_live();
        return vm_run && (vm_steps <= int'(vm_limit));
    endfunction

    // Execute one instruction on the predictor state and return the result it gives.
    function automatic vm_result_t execute_instr(input logic [ACT_W-1:0] act,
                                                 input logic [DATA_W-1:0] opnd);
        vm_result_t        r;
        int                need;
        bit                grows;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] sec;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] quot;
        logic [IP_W-1:0]   nxt;
        r = '0;
        need = 0;
        grows = 1'b0;
        top = '0;
        sec = '0;
        val = '0;
        nxt = vm_ip + 16'd1;
        if (!vm_live())
        begin
            r.status = STS_STOPPED;
            nxt = vm_ip;
        end
        else
        begin
            case (act) inside
                OP_PUSH: grows = 1'b1;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                begin
                    need = 2;
                    grows = 1'b1;
                end
                OP_PRINT: need = 1;
                OP_DUP:
                begin
                    need = 1;
                    grows = 1'b1;
                end
                default: ;
            endcase
            if (act > OP_HALT)
                r.status = STS_UNKNOWN;
            else if (vm_sp < need)
                r.status = STS_UNDERFLOW;
            else if (grows && vm_sp >= STACK_DEPTH)
                r.status = STS_OVERFLOW;
            else
            begin
                if (need >= 1)
                    top = vm_stack[vm_sp - 1];
                if (need >= 2)
                    sec = vm_stack[vm_sp - 2];
                case (act)
                    OP_PUSH: val = opnd;
                    OP_ADD: val = sec + top;
                    OP_SUB: val = sec - top;
                    OP_MUL: val = sec * top;
                    OP_DIV:
                    begin
                        if (top == '0)
                            r.status = STS_DIVZERO;
                        else
                        begin
                            // divide magnitudes, then fix the sign: truncates toward zero
                            num_mag = sec[31] ? (32'd0 - sec) : sec;
                            den_mag = top[31] ? (32'd0 - top) : top;
                            quot = num_mag / den_mag;
                            val = (sec[31] != top[31]) ? (32'd0 - quot) : quot;
                        end
                    end
                    OP_PRINT:
                    begin
                        r.print_valid = 1'b1;
                        r.print_value = top;
                    end
                    OP_JMP: nxt = opnd[IP_W-1:0];
                    OP_DUP: val = top;
                    OP_HALT: vm_run = 1'b0;
                    default: ;
                endcase
                if (grows && r.status == STS_OK)
                begin
                    vm_stack[vm_sp] = val;
                    vm_sp++;
                end
            end
            vm_ip = nxt;
            vm_steps++;
        end
        r.next_ip = nxt;
        r.is_running = vm_live();
        r.stack_count = vm_sp[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    // Present one instruction and hold it until the transfer; enter and leave at a falling edge.
    task automatic send_instr(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] opnd,
                              input bit typed, input vm_result_t typed_res);
        vm_result_t pred;
        int         gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= opnd;
        do
            @(posedge clk);
        while (!s_tready);
        pred = execute_instr(act, opnd);
        awaited_results.push_back(typed ? typed_res : pred);
        @(negedge clk);
    endtask

    task automatic write_step_limit(input logic [LIMIT_W-1:0] value);
        while (awaited_results.size() != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        vm_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_instr(output logic [ACT_W-1:0] act, output logic [DATA_W-1:0] opnd);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            act = OP_PUSH;
        else if (pick < 11)
            act = OP_ADD;
        else if (pick < 14)
            act = OP_SUB;
        else if (pick < 17)
            act = OP_MUL;
        else if (pick < 22)
            act = OP_DIV;
        else if (pick < 25)
            act = OP_DUP;
        else if (pick < 52)
            act = OP_PRINT;
        else if (pick < 80)
            act = OP_JMP;
        else
            act = ACT_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        case ($urandom_range(0, 7)) inside
            0: opnd = 32'h8000_0000;
            1: opnd = 32'h7FFF_FFFF;
            2: opnd = 32'hFFFF_FFFF;
            3, 4: opnd = 32'($urandom_range(0, 16)) - 32'd8;
            default: opnd = $urandom;
        endcase
    endtask

    // receiver back-pressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        vm_result_t got;
        vm_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tuser[2:0];
            got.print_valid = m_tuser[3];
            got.print_value = m_tdata[31:0];
            got.next_ip = m_tdata[47:32];
            got.is_running = m_tdata[48];
            got.stack_count = m_tdata[55:49];
            if (awaited_results.size() == 0)
                report_mismatch("result with none awaited, status", 32'(got.status), '0);
            else
            begin
                want = awaited_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.print_valid !== want.print_valid)
                    report_mismatch("print_valid", 32'(got.print_valid), 32'(want.print_valid));
                if (got.print_value !== want.print_value)
                    report_mismatch("print_value", got.print_value, want.print_value);
                if (got.next_ip !== want.next_ip)
                    report_mismatch("next_ip", 32'(got.next_ip), 32'(want.next_ip));
                if (got.is_running !== want.is_running)
                    report_mismatch("is_running", 32'(got.is_running), 32'(want.is_running));
                if (got.stack_count !== want.stack_count)
                    report_mismatch("stack_count", 32'(got.stack_count), 32'(want.stack_count));
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL stack_machine_executor");
            $finish;
        end
    end

    initial
    begin
        vm_result_t        typed_res;
        logic [ACT_W-1:0]  act;
        logic [DATA_W-1:0] opnd;
        logic [LIMIT_W-1:0] limit;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        vm_sp = 0;
        vm_ip = '0;
        vm_run = 1'b1;
        vm_steps = 0;
        vm_limit = LIMIT_RESET;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed program under the reset step limit
        foreach (directed_program[i])
        begin
            typed_res.status = directed_program[i].status;
            typed_res.print_valid = directed_program[i].pvalid;
            typed_res.print_value = directed_program[i].pvalue;
            typed_res.next_ip = directed_program[i].nip;
            typed_res.is_running = directed_program[i].running;
            typed_res.stack_count = directed_program[i].depth;
            send_instr(directed_program[i].act, directed_program[i].opnd,
                       directed_program[i].typed, typed_res);
        end
        s_tvalid <= 1'b0;

        // a zero limit stops a machine that has already run
        write_step_limit(LIMIT_MIN);
        repeat (3)
        begin
            random_instr(act, opnd);
            send_instr(act, opnd, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            idle_on = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            case ((p == PHASES - 1) ? 0 : $urandom_range(0, 3))
                0: limit = LIMIT_MAX;
                1: limit = LIMIT_W'(vm_steps + $urandom_range(0, PHASE_ITEMS - 1));
                2: limit = LIMIT_W'($urandom);
                default: limit = LIMIT_W'($urandom_range(0, vm_steps));
            endcase
            write_step_limit(limit);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                random_instr(act, opnd);
                send_instr(act, opnd, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        // halt stops the machine for good, so it comes last
        write_step_limit(LIMIT_MAX);
        send_instr(OP_HALT, $urandom, 1'b0, '0);
        repeat (3)
        begin
            random_instr(act, opnd);
            send_instr(act, opnd, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS stack_machine_executor");
        else
            $display("FAIL stack_machine_executor");
        $finish;
    end

endmodule
